>>> rtl/prx_pkg.sv
package prx_pkg;

	localparam int CW    = 24;          // coordinate width
	localparam int VW    = CW + 1;      // line direction and point offset
	localparam int SW    = CW + 2;      // 2*A - P
	localparam int PW    = 2 * VW;      // one product of two VW values
	localparam int NUMW  = PW + 2;      // signed dot product d.v
	localparam int DENW  = PW;          // v.v, never negative
	localparam int NABS  = PW;          // magnitude of d.v
	localparam int MAGW  = VW + 1;      // magnitude of 2*v_i
	localparam int HALF  = NABS / 2;    // split point of the wide product
	localparam int PPW   = (NABS - HALF) + MAGW;
	localparam int TW    = NABS + MAGW; // dividend width
	localparam int QW    = VW + 1;      // quotient bits
	localparam int RW    = SW + 2;      // unsaturated mirror coordinate

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] line_a_x;
		logic signed [CW-1:0] line_a_y;
		logic signed [CW-1:0] line_a_z;
		logic signed [CW-1:0] line_b_x;
		logic signed [CW-1:0] line_b_y;
		logic signed [CW-1:0] line_b_z;
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
	} in_item_t;

	typedef struct packed {
		logic signed [CW-1:0] mirror_x;
		logic signed [CW-1:0] mirror_y;
		logic signed [CW-1:0] mirror_z;
		logic                 degenerate;
		logic                 clipped;
	} out_item_t;

	// Payload of the divider pipeline, one lane per axis.
	typedef struct packed {
		logic [2:0][TW-1:0]   rem;
		logic [2:0][QW-1:0]   quo;
		logic [TW-1:0]        dsh;
		logic [DENW-1:0]      den;
		logic [2:0]           neg;
		logic [2:0][SW-1:0]   a2mp;
		logic [2:0][CW-1:0]   pt;
		logic                 degen;
	} div_t;

	typedef struct packed {
		logic [2:0][QW:0]     qr;
		logic [2:0]           neg;
		logic [2:0][SW-1:0]   a2mp;
		logic [2:0][CW-1:0]   pt;
		logic                 degen;
	} rnd_t;

endpackage

>>> rtl/point_reflection_across_line_3d.sv
// Channel  Signals                          Payload
// in       in_valid / in_ready / in_data    in_item_t: line points A, B and point P
// out      out_valid / out_ready / out_data out_item_t: mirror point, degenerate, clipped
//
// One item enters per cycle when nothing stalls.
// The depth is set by the restoring divider, one quotient bit per stage for all three axes.
// Reset clears the valid bits of every stage; data registers are not reset.
// Each stage holds its item until the next one frees up, so bubbles close up under a stall.
module point_reflection_across_line_3d
	import prx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic dv  [QW+1];
	logic dr  [QW+1];
	div_t dd  [QW+1];

	prx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (dv[0]),
		.out_ready (dr[0]),
		.out_data  (dd[0])
	);

	for (genvar k = 0; k < QW; k++) begin : g_div
		prx_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[k]),
			.in_ready  (dr[k]),
			.in_data   (dd[k]),
			.out_valid (dv[k+1]),
			.out_ready (dr[k+1]),
			.out_data  (dd[k+1])
		);
	end

	prx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv[QW]),
		.in_ready  (dr[QW]),
		.in_data   (dd[QW]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> rtl/prx_front.sv
module prx_front
	import prx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output div_t     out_data
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic signed [CW-1:0] a [3];
	logic signed [CW-1:0] b [3];
	logic signed [CW-1:0] p [3];

	logic signed [VW-1:0] v_s1 [3];
	logic signed [VW-1:0] d_s1 [3];
	logic [2:0][SW-1:0]   a2mp_s1, a2mp_s2, a2mp_s3, a2mp_s4, a2mp_s5, a2mp_s6;
	logic [2:0][CW-1:0]   pt_s1, pt_s2, pt_s3, pt_s4, pt_s5, pt_s6;
	logic                 degen_s1, degen_s2, degen_s3, degen_s4, degen_s5, degen_s6;

	logic signed [PW-1:0] pdv_s2 [3];
	logic signed [PW-1:0] pvv_s2 [3];
	logic signed [VW-1:0] v_s2 [3];

	logic signed [NUMW-1:0] num_s3;
	logic [DENW-1:0]        den_s3, den_s4, den_s5, den_s6;
	logic signed [VW-1:0]   v_s3 [3];

	logic [NABS-1:0]      nabs_s4;
	logic [MAGW-1:0]      vabs_s4 [3];
	logic [2:0]           neg_s4, neg_s5, neg_s6;

	logic [PPW-1:0]       ml_s5 [3];
	logic [PPW-1:0]       mh_s5 [3];

	logic [TW-1:0]        t_s6 [3];

	// A stage takes a new item when it is empty or its item moves on.
	assign rdy6     = !vld_s6 || out_ready;
	assign rdy5     = !vld_s5 || rdy6;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		a[0] = in_data.line_a_x; a[1] = in_data.line_a_y; a[2] = in_data.line_a_z;
		b[0] = in_data.line_b_x; b[1] = in_data.line_b_y; b[2] = in_data.line_b_z;
		p[0] = in_data.point_x;  p[1] = in_data.point_y;  p[2] = in_data.point_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: direction, offset and 2*A - P.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i]    <= VW'(b[i]) - VW'(a[i]);
				d_s1[i]    <= VW'(p[i]) - VW'(a[i]);
				a2mp_s1[i] <= (SW'(a[i]) <<< 1) - SW'(p[i]);
				pt_s1[i]   <= p[i];
			end
			degen_s1 <= (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
		end
	end

	// Stage 2: the six products.
	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			for (int i = 0; i < 3; i++) begin
				pdv_s2[i] <= PW'(d_s1[i]) * PW'(v_s1[i]);
				pvv_s2[i] <= PW'(v_s1[i]) * PW'(v_s1[i]);
				v_s2[i]   <= v_s1[i];
			end
			a2mp_s2  <= a2mp_s1;
			pt_s2    <= pt_s1;
			degen_s2 <= degen_s1;
		end
	end

	// Stage 3: dot products.
	always_ff @(posedge clk) begin
		if (rdy3 && vld_s2) begin
			num_s3 <= NUMW'(pdv_s2[0]) + NUMW'(pdv_s2[1]) + NUMW'(pdv_s2[2]);
			den_s3 <= DENW'($unsigned(pvv_s2[0])) + DENW'($unsigned(pvv_s2[1]))
				+ DENW'($unsigned(pvv_s2[2]));
			for (int i = 0; i < 3; i++) v_s3[i] <= v_s2[i];
			a2mp_s3  <= a2mp_s2;
			pt_s3    <= pt_s2;
			degen_s3 <= degen_s2;
		end
	end

	// Stage 4: magnitudes and signs of the scaled numerators.
	always_ff @(posedge clk) begin
		if (rdy4 && vld_s3) begin
			nabs_s4 <= num_s3[NUMW-1] ? NABS'(-num_s3) : NABS'(num_s3);
			for (int i = 0; i < 3; i++) begin
				vabs_s4[i] <= v_s3[i][VW-1] ? {VW'(-v_s3[i]), 1'b0} : {v_s3[i], 1'b0};
				neg_s4[i]  <= num_s3[NUMW-1] ^ v_s3[i][VW-1];
			end
			den_s4   <= den_s3;
			a2mp_s4  <= a2mp_s3;
			pt_s4    <= pt_s3;
			degen_s4 <= degen_s3;
		end
	end

	// Stage 5: the wide product in two halves.
	always_ff @(posedge clk) begin
		if (rdy5 && vld_s4) begin
			for (int i = 0; i < 3; i++) begin
				ml_s5[i] <= PPW'(nabs_s4[HALF-1:0]) * PPW'(vabs_s4[i]);
				mh_s5[i] <= PPW'(nabs_s4[NABS-1:HALF]) * PPW'(vabs_s4[i]);
			end
			neg_s5   <= neg_s4;
			den_s5   <= den_s4;
			a2mp_s5  <= a2mp_s4;
			pt_s5    <= pt_s4;
			degen_s5 <= degen_s4;
		end
	end

	// Stage 6: combine halves into the dividend.
	always_ff @(posedge clk) begin
		if (rdy6 && vld_s5) begin
			for (int i = 0; i < 3; i++)
				t_s6[i] <= (TW'(mh_s5[i]) << HALF) + TW'(ml_s5[i]);
			neg_s6   <= neg_s5;
			den_s6   <= den_s5;
			a2mp_s6  <= a2mp_s5;
			pt_s6    <= pt_s5;
			degen_s6 <= degen_s5;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_data.rem[i] = t_s6[i];
			out_data.quo[i] = '0;
		end
		out_data.dsh   = TW'(den_s6) << (QW - 1);
		out_data.den   = den_s6;
		out_data.neg   = neg_s6;
		out_data.a2mp  = a2mp_s6;
		out_data.pt    = pt_s6;
		out_data.degen = degen_s6;
	end

	assign out_valid = vld_s6;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted item did not enter the first stage");

endmodule

>>> rtl/prx_div_step.sv
module prx_div_step
	import prx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic vld_q;
	div_t dat_q;
	div_t nxt;
	logic ge;

	assign in_ready = !vld_q || out_ready;

	// One restoring step per lane; the aligned divisor moves down one bit.
	always_comb begin
		nxt = in_data;
		for (int i = 0; i < 3; i++) begin
			ge          = in_data.rem[i] >= in_data.dsh;
			nxt.rem[i]  = ge ? in_data.rem[i] - in_data.dsh : in_data.rem[i];
			nxt.quo[i]  = {in_data.quo[i][QW-2:0], ge};
		end
		nxt.dsh = in_data.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_data  = dat_q;

	// The last shift drops the low divisor bit, so the window is one wider than twice dsh.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !dat_q.degen) |->
			({1'b0, dat_q.rem[0]} < {dat_q.dsh, 1'b1}) &&
			({1'b0, dat_q.rem[1]} < {dat_q.dsh, 1'b1}) &&
			({1'b0, dat_q.rem[2]} < {dat_q.dsh, 1'b1}))
		else $error("partial remainder exceeds the divisor window");

endmodule

>>> rtl/prx_back.sv
module prx_back
	import prx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_t      in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic vld_s1, vld_s2;
	logic rdy1, rdy2;
	rnd_t rnd_s1;
	out_item_t res_s2;

	logic signed [RW-1:0] off [3];
	logic signed [RW-1:0] r   [3];
	logic signed [CW-1:0] m   [3];
	logic [2:0]           clp;

	assign rdy2     = !vld_s2 || out_ready;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
		end
	end

	// Round to nearest, ties away from zero, on the magnitude.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				rnd_s1.qr[i] <= (QW+1)'(in_data.quo[i]) + (QW+1)'(
					{in_data.rem[i][DENW-1:0], 1'b0} >= {1'b0, in_data.den});
			end
			rnd_s1.neg   <= in_data.neg;
			rnd_s1.a2mp  <= in_data.a2mp;
			rnd_s1.pt    <= in_data.pt;
			rnd_s1.degen <= in_data.degen;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i] = rnd_s1.neg[i] ? -RW'(rnd_s1.qr[i]) : RW'(rnd_s1.qr[i]);
			r[i]   = RW'($signed(rnd_s1.a2mp[i])) + off[i];
			if (r[i] > RW'(CMAX)) begin
				m[i]   = CMAX;
				clp[i] = 1'b1;
			end else if (r[i] < RW'(CMIN)) begin
				m[i]   = CMIN;
				clp[i] = 1'b1;
			end else begin
				m[i]   = CW'(r[i]);
				clp[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			if (rnd_s1.degen) begin
				res_s2.mirror_x <= rnd_s1.pt[0];
				res_s2.mirror_y <= rnd_s1.pt[1];
				res_s2.mirror_z <= rnd_s1.pt[2];
				res_s2.clipped  <= 1'b0;
			end else begin
				res_s2.mirror_x <= m[0];
				res_s2.mirror_y <= m[1];
				res_s2.mirror_z <= m[2];
				res_s2.clipped  <= |clp;
			end
			res_s2.degenerate <= rnd_s1.degen;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.degenerate) |-> !res_s2.clipped)
		else $error("degenerate item flagged as clipped");

	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !rnd_s1.degen) |-> (rnd_s1.qr[0][QW] == 1'b0))
		else $error("rounded quotient out of range");

endmodule

>>> verif/point_reflection_across_line_3d_test.sv
module point_reflection_across_line_3d_test
	import prx_pkg::*;
;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	out_item_t mirror_queue[$];
	int errors = 0;
	longint cycle = 0;
	int gap_max = 3;
	bit hold_off = 1'b0;

	localparam longint CYCLE_LIMIT = 400000;

	point_reflection_across_line_3d DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// Divides a nonnegative value by a positive one, rounding half up.
	function automatic logic [255:0] round_div(logic [255:0] num, logic [255:0] den);
		logic [255:0] q;
		logic [255:0] rem;
		begin
			q = num / den;
			rem = num % den;
			if ((rem << 1) >= den) q = q + 1;
			return q;
		end
	endfunction

	function automatic out_item_t reflect(in_item_t it);
		out_item_t res;
		logic signed [255:0] a[3], b[3], p[3], v[3], d[3];
		logic signed [255:0] dot, len2, t, off, r;
		logic [255:0] mag;
		logic signed [255:0] hi, lo;
		begin
			a[0] = it.line_a_x; a[1] = it.line_a_y; a[2] = it.line_a_z;
			b[0] = it.line_b_x; b[1] = it.line_b_y; b[2] = it.line_b_z;
			p[0] = it.point_x; p[1] = it.point_y; p[2] = it.point_z;
			hi = CMAX;
			lo = CMIN;
			dot = 0;
			len2 = 0;
			res = '0;
			for (int i = 0; i < 3; i++) begin
				v[i] = b[i] - a[i];
				d[i] = p[i] - a[i];
				dot += d[i] * v[i];
				len2 += v[i] * v[i];
			end
			if (len2 == 0) begin
				res.mirror_x = it.point_x;
				res.mirror_y = it.point_y;
				res.mirror_z = it.point_z;
				res.degenerate = 1'b1;
				return res;
			end
			for (int i = 0; i < 3; i++) begin
				t = dot * 2 * v[i];
				mag = round_div((t < 0) ? -t : t, len2);
				off = (t < 0) ? -$signed(mag) : $signed(mag);
				r = 2 * a[i] - p[i] + off;
				if (r > hi) begin
					r = hi;
					res.clipped = 1'b1;
				end
				if (r < lo) begin
					r = lo;
					res.clipped = 1'b1;
				end
				if (i == 0) res.mirror_x = r[CW-1:0];
				else if (i == 1) res.mirror_y = r[CW-1:0];
				else res.mirror_z = r[CW-1:0];
			end
			return res;
		end
	endfunction

	task automatic send_item(in_item_t it);
		int gap;
		begin
			gap = (gap_max == 0) ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, gap_max) : 0);
			repeat (gap) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_data <= it;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			mirror_queue = {mirror_queue, reflect(it)};
		end
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return CMAX;
			1: return CMIN;
			2: return CW'(int'($urandom_range(0, 2047)) - 1024);
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		begin
			it = '0;
			it.line_a_x = rand_coord(); it.line_a_y = rand_coord(); it.line_a_z = rand_coord();
			it.line_b_x = rand_coord(); it.line_b_y = rand_coord(); it.line_b_z = rand_coord();
			it.point_x = rand_coord(); it.point_y = rand_coord(); it.point_z = rand_coord();
			case ($urandom_range(0, 9))
				0: begin
					it.line_b_x = it.line_a_x; it.line_b_y = it.line_a_y; it.line_b_z = it.line_a_z;
				end
				1: begin
					// Short direction vector: quotient rounding dominates.
					it.line_b_x = CW'(it.line_a_x + int'($urandom_range(0, 4)) - 2);
					it.line_b_y = it.line_a_y;
					it.line_b_z = CW'(it.line_a_z + int'($urandom_range(0, 2)) - 1);
				end
				2: begin
					it.point_x = it.line_a_x; it.point_y = it.line_a_y; it.point_z = it.line_a_z;
				end
				default: ;
			endcase
			return it;
		end
	endfunction

	task automatic test_extremes();
		in_item_t it;
		begin
			it = '0;
			send_item(it);
			it = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN};
			send_item(it);
			it = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN};
			send_item(it);
			it = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN};
			send_item(it);
			it = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX};
			send_item(it);
			// Line along x through the origin, point far off: the mirror saturates.
			it = '{24'sd0, 24'sd0, 24'sd0, 24'sd256, 24'sd0, 24'sd0, 24'sd0, CMAX, CMIN};
			send_item(it);
			it = '{24'sd0, CMAX, 24'sd0, 24'sd1, CMAX, 24'sd0, 24'sd5, CMIN, 24'sd3};
			send_item(it);
		end
	endtask

	task automatic test_degenerate_and_rounding();
		in_item_t it;
		begin
			it = '{24'sd7, -24'sd9, 24'sd3, 24'sd7, -24'sd9, 24'sd3, CMAX, CMIN, 24'sd1};
			send_item(it);
			it = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN};
			send_item(it);
			// v = (2,1,0), d = (1,0,0): fractional offsets of 8/5 and 4/5.
			it = '{24'sd0, 24'sd0, 24'sd0, 24'sd2, 24'sd1, 24'sd0, 24'sd1, 24'sd0, 24'sd0};
			send_item(it);
			it = '{24'sd0, 24'sd0, 24'sd0, 24'sd2, 24'sd1, 24'sd0, -24'sd1, 24'sd0, 24'sd0};
			send_item(it);
			it = '{24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd1, 24'sd1, 24'sd0, 24'sd0};
			send_item(it);
			it = '{24'sd0, 24'sd0, 24'sd0, 24'sd3, 24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sd1};
			send_item(it);
			it = '{24'sd0, 24'sd0, 24'sd0, -24'sd3, 24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1};
			send_item(it);
		end
	endtask

	task automatic test_backpressure();
		begin
			gap_max = 0;
			hold_off = 1'b1;
			repeat (80) send_item(rand_item());
			gap_max = 3;
		end
	endtask

	task automatic test_random(int count);
		begin
			for (int n = 0; n < count; n++) begin
				if (n % 300 == 0) gap_max = (gap_max == 0) ? 4 : 0;
				send_item(rand_item());
			end
		end
	endtask

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("point_reflection_across_line_3d: mismatch");
			$finish;
		end
	end

	// Receiver: stalls in a repeating pattern, plus one long hold-off on request.
	initial begin
		int held;
		int phase;
		held = 0;
		phase = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && held < 200) begin
				out_ready <= 1'b0;
				held++;
			end else begin
				hold_off = 1'b0;
				phase = (phase + 1) % 23;
				out_ready <= (phase < 14) ? 1'b1 :
					((phase < 17) ? 1'b0 : 1'($urandom_range(0, 1)));
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (mirror_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected item %p", $time, out_data);
			end else begin
				want = mirror_queue.pop_front();
				if (out_data.mirror_x !== want.mirror_x)
					$display("%0t: mirror_x expected %0d actual %0d", $time, want.mirror_x, out_data.mirror_x);
				if (out_data.mirror_y !== want.mirror_y)
					$display("%0t: mirror_y expected %0d actual %0d", $time, want.mirror_y, out_data.mirror_y);
				if (out_data.mirror_z !== want.mirror_z)
					$display("%0t: mirror_z expected %0d actual %0d", $time, want.mirror_z, out_data.mirror_z);
				if (out_data.degenerate !== want.degenerate)
					$display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate, out_data.degenerate);
				if (out_data.clipped !== want.clipped)
					$display("%0t: clipped expected %0b actual %0b", $time, want.clipped, out_data.clipped);
				if (out_data !== want) errors++;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_degenerate_and_rounding();
		test_backpressure();
		test_random(1750);
		go_idle();
		while (mirror_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && !out_valid) begin
			$display("point_reflection_across_line_3d: match");
		end else begin
			$display("point_reflection_across_line_3d: mismatch");
		end
		$finish;
	end

endmodule
